// ===== hdl/priority_queue_with_patience_macros.svh =====
// assertion macros for the visitor priority queue
// no dependencies; included by modules that carry checks
`ifndef PRIORITY_QUEUE_WITH_PATIENCE_MACROS_SVH
`define PRIORITY_QUEUE_WITH_PATIENCE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PQWP_ASSERT_NOW(label, clk, rst, cond, concl, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (concl)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PQWP_ASSERT_NEXT(label, clk, rst, cond, concl, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (concl)) \
      else $error(msg);

`endif

// ===== hdl/pqwp_pkg.sv =====
// shared types and codes for the visitor priority queue
// used by pqwp_cell, pqwp_chain and priority_queue_with_patience
package pqwp_pkg;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  prio;
      logic [7:0]  pat;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP,
      CELL_TICK
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   new_entry;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      KIND_ENQ  = 2'd0,
      KIND_DEQ  = 2'd1,
      KIND_TICK = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_ENQUEUED  = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_DEQUEUED  = 3'd2,
      STATUS_EMPTY     = 3'd3,
      STATUS_LEFT      = 3'd4,
      STATUS_NONE_LEFT = 3'd5
   } status_type;

   // most departures one tick may produce
   localparam int MAX_RES = 16;
   typedef logic [$clog2(MAX_RES)-1:0] drained_type;

   typedef logic [4:0] count_res_type;
   typedef logic [4:0] capacity_type;
   localparam capacity_type CAPACITY_RESET = 5'd16;

endpackage

// ===== hdl/pqwp_cell.sv =====
// one slot of the sorted systolic store
// depends on pqwp_pkg for the entry and control types
module pqwp_cell (
   input  logic                  clock,
   input  pqwp_pkg::cell_ctl_type ctl,
   input  pqwp_pkg::entry_type   left_entry,
   input  logic                  left_gt,
   input  pqwp_pkg::entry_type   right_entry,
   input  logic                  occupied,
   input  logic                  at_tail,
   output pqwp_pkg::entry_type   entry,
   output logic                  gt
);

   pqwp_pkg::entry_type entry_ff;
   pqwp_pkg::entry_type entry_in;

   // new entry goes ahead of this one
   assign gt    = occupied && (ctl.new_entry.prio < entry_ff.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         pqwp_pkg::CELL_INSERT: begin
            if (left_gt) begin
               entry_in = left_entry;
            end else if (gt || at_tail) begin
               entry_in = ctl.new_entry;
            end
         end
         pqwp_pkg::CELL_POP: begin
            entry_in = right_entry;
         end
         pqwp_pkg::CELL_TICK: begin
            if (entry_ff.pat != 8'd0) begin
               entry_in.pat = entry_ff.pat - 8'd1;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hdl/pqwp_chain.sv =====
// row of pqwp_cell slots kept in priority order, head at slot 0
// depends on pqwp_pkg and pqwp_cell
module pqwp_chain #(
   parameter int DEPTH = 16,
   parameter int CW    = 5
) (
   input  logic                   clock,
   input  pqwp_pkg::cell_ctl_type ctl,
   input  logic [CW-1:0]          count,
   output pqwp_pkg::entry_type    head,
   output pqwp_pkg::entry_type    second
);

   pqwp_pkg::entry_type entry_w [DEPTH];
   logic                gt_w    [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      pqwp_pkg::entry_type left_w;
      pqwp_pkg::entry_type right_w;
      logic                left_gt_w;

      if (i == 0) begin : g_first
         assign left_w    = ctl.new_entry;
         assign left_gt_w = 1'b0;
      end else begin : g_inner
         assign left_w    = entry_w[i-1];
         assign left_gt_w = gt_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w = entry_w[i];
      end else begin : g_mid
         assign right_w = entry_w[i+1];
      end

      pqwp_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .left_entry  (left_w),
         .left_gt     (left_gt_w),
         .right_entry (right_w),
         .occupied    (count > CW'(i)),
         .at_tail     (count == CW'(i)),
         .entry       (entry_w[i]),
         .gt          (gt_w[i])
      );
   end

   assign head   = entry_w[0];
   assign second = entry_w[1];

endmodule

// ===== hdl/priority_queue_with_patience.sv =====
// channel  | dir | handshake                | beat
// req      | in  | req_valid / req_ready    | kind, visitor id, priority, patience
// rsp      | out | rsp_valid / rsp_ready    | status, removed entry, count, last
// csr      | in  | csr_valid / csr_ready    | capacity
//
// enqueue and dequeue: result registered the next cycle after acceptance.
// tick: ages every slot, then pops one departure per result beat (up to 16),
//   or gives the no-departure result; departures pop the cell chain.
// a new request is taken only when idle and the result register is free or draining.
// reset: synchronous; empties the queue and sets capacity to 16, slots keep garbage.
// a stalled rsp holds the chain and the tick drain until the beat is taken.
//
// top level of the visitor priority queue; depends on pqwp_pkg, pqwp_chain
// and priority_queue_with_patience_macros.svh
`include "priority_queue_with_patience_macros.svh"

module priority_queue_with_patience #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_visitor_id,
   input  logic [7:0]  req_priority_req,
   input  logic [7:0]  req_patience,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_visitor_id_res,
   output logic [7:0]  rsp_priority_res,
   output logic [7:0]  rsp_patience_res,
   output logic [4:0]  rsp_count,
   output logic        rsp_last,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_capacity
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   pqwp_pkg::drained_type    drained_ff, drained_in;
   pqwp_pkg::capacity_type   capacity_ff, capacity_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   pqwp_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [15:0]              rsp_id_ff, rsp_id_in;
   logic [7:0]               rsp_prio_ff, rsp_prio_in;
   logic [7:0]               rsp_pat_ff, rsp_pat_in;
   pqwp_pkg::count_res_type  rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   pqwp_pkg::cell_ctl_type   ctl;
   pqwp_pkg::entry_type      head;
   pqwp_pkg::entry_type      second;

   logic in_fire;
   logic rsp_free;
   logic full;
   logic head_due;
   logic next_due;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign in_fire   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign full     = (32'(count_ff) >= 32'(capacity_ff)) || (32'(count_ff) >= DEPTH);
   assign head_due = (count_ff != '0) && (head.pat == 8'd0);
   // slot 1 becomes the head after this pop; stop at the per-tick departure limit
   assign next_due = (count_ff > CW'(1)) && (second.pat == 8'd0)
                     && (drained_ff != pqwp_pkg::drained_type'(pqwp_pkg::MAX_RES - 1));

   pqwp_chain #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_chain (
      .clock  (clock),
      .ctl    (ctl),
      .count  (count_ff),
      .head   (head),
      .second (second)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      drained_in    = drained_ff;
      capacity_in   = capacity_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_pat_in    = rsp_pat_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      ctl.op        = pqwp_pkg::CELL_HOLD;
      ctl.new_entry = '{id: req_visitor_id, prio: req_priority_req, pat: req_patience};

      if (csr_valid && csr_ready) begin
         capacity_in = csr_capacity;
      end

      case (state_ff)
         ST_IDLE: begin
            if (in_fire) begin
               case (pqwp_pkg::kind_type'(req_kind))
                  pqwp_pkg::KIND_ENQ: begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = '0;
                     rsp_prio_in  = '0;
                     rsp_pat_in   = '0;
                     rsp_last_in  = 1'b1;
                     if (full) begin
                        rsp_status_in = pqwp_pkg::STATUS_FULL;
                     end else begin
                        ctl.op        = pqwp_pkg::CELL_INSERT;
                        count_in      = count_ff + CW'(1);
                        rsp_status_in = pqwp_pkg::STATUS_ENQUEUED;
                     end
                     rsp_count_in = pqwp_pkg::count_res_type'(count_in);
                  end
                  pqwp_pkg::KIND_DEQ: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = pqwp_pkg::STATUS_EMPTY;
                        rsp_id_in     = '0;
                        rsp_prio_in   = '0;
                        rsp_pat_in    = '0;
                     end else begin
                        ctl.op        = pqwp_pkg::CELL_POP;
                        count_in      = count_ff - CW'(1);
                        rsp_status_in = pqwp_pkg::STATUS_DEQUEUED;
                        rsp_id_in     = head.id;
                        rsp_prio_in   = head.prio;
                        rsp_pat_in    = head.pat;
                     end
                     rsp_count_in = pqwp_pkg::count_res_type'(count_in);
                  end
                  pqwp_pkg::KIND_TICK: begin
                     // age every slot, departures follow in the drain state
                     ctl.op     = pqwp_pkg::CELL_TICK;
                     state_in   = ST_DRAIN;
                     drained_in = '0;
                  end
                  default: begin
                     // unused kind: taken, no result
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (head_due) begin
                  ctl.op        = pqwp_pkg::CELL_POP;
                  count_in      = count_ff - CW'(1);
                  drained_in    = drained_ff + 1'b1;
                  rsp_status_in = pqwp_pkg::STATUS_LEFT;
                  rsp_id_in     = head.id;
                  rsp_prio_in   = head.prio;
                  rsp_pat_in    = head.pat;
                  rsp_last_in   = !next_due;
                  if (!next_due) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  // only reached before the first departure
                  rsp_status_in = pqwp_pkg::STATUS_NONE_LEFT;
                  rsp_id_in     = '0;
                  rsp_prio_in   = '0;
                  rsp_pat_in    = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end
               rsp_count_in = pqwp_pkg::count_res_type'(count_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         drained_ff    <= '0;
         capacity_ff   <= pqwp_pkg::CAPACITY_RESET;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= pqwp_pkg::STATUS_ENQUEUED;
         rsp_id_ff     <= '0;
         rsp_prio_ff   <= '0;
         rsp_pat_ff    <= '0;
         rsp_count_ff  <= '0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         drained_ff    <= drained_in;
         capacity_ff   <= capacity_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_pat_ff    <= rsp_pat_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_visitor_id_res = rsp_id_ff;
   assign rsp_priority_res   = rsp_prio_ff;
   assign rsp_patience_res   = rsp_pat_ff;
   assign rsp_count          = rsp_count_ff;
   assign rsp_last           = rsp_last_ff;

   `PQWP_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, 32'(count_ff) <= DEPTH, "count above depth")
   `PQWP_ASSERT_NEXT(a_tick_drains, clock, reset,
      in_fire && (req_kind == pqwp_pkg::KIND_TICK), state_ff == ST_DRAIN, "tick did not drain")
   `PQWP_ASSERT_NOW(a_left_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff == pqwp_pkg::STATUS_LEFT), rsp_pat_ff == 8'd0,
      "departed entry with patience left")
   `PQWP_ASSERT_NEXT(a_pop_count, clock, reset,
      ctl.op == pqwp_pkg::CELL_POP, count_ff == $past(count_ff) - CW'(1), "pop lost count")

endmodule
